/* rtl/brle_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brle_pkg
// Shared types, constants and the code layout function for the run-length
// byte encoder.
// ----------------------------------------------------------------------------
package brle_pkg;

	localparam int RUN_BITS_DEF = 32;

	localparam logic [2:0] SYM_END    = 3'd4;
	localparam logic       OP_APPEND  = 1'b0;
	localparam logic       OP_FLUSH   = 1'b1;

	localparam logic [7:0] END_BASE   = 8'd252;
	localparam logic [5:0] END_LIMIT  = 6'd3;
	localparam logic [7:0] END_FULL   = 8'd255;
	localparam logic [5:0] ENDS_LIMIT = 6'd62;
	localparam logic [5:0] STD_LIMIT  = 6'd63;
	localparam logic [7:0] GROUP_MORE = 8'd128;

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_HEAD  = 3'b010,
		ST_GROUP = 3'b100
	} brle_state_t;

	typedef struct packed {
		logic accept;
		logic emit_head;
		logic emit_group;
	} brle_cmd_t;

	typedef struct packed {
		logic emit_req;
		logic short_run;
		logic final_group;
		logic out_free;
	} brle_sts_t;

	typedef struct packed {
		logic [7:0] base;
		logic [5:0] limit;
		logic [7:0] full;
	} brle_layout_t;

	function automatic brle_layout_t code_layout(input logic [2:0] sym, input logic ends);
		brle_layout_t l;
		logic [7:0]   s8;
		s8 = 8'(sym);
		if (sym >= SYM_END) begin
			l.base  = END_BASE;
			l.limit = END_LIMIT;
			l.full  = END_FULL;
		end else if (ends) begin
			l.base  = (s8 << 6) - s8;
			l.limit = ENDS_LIMIT;
			l.full  = l.base + 8'(ENDS_LIMIT);
		end else begin
			l.base  = s8 << 6;
			l.limit = STD_LIMIT;
			l.full  = l.base + 8'(STD_LIMIT);
		end
		return l;
	endfunction

endpackage

/* rtl/brle_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brle_ctrl
// Sequencer: takes a request when idle, then steps through the head byte
// and the 7-bit groups of a run as the output register frees up.
// ----------------------------------------------------------------------------
module brle_ctrl import brle_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  brle_sts_t sts,
	output brle_cmd_t cmd,
	output logic      busy
);

	brle_state_t state_q, state_d;

	always_comb begin
		state_d        = state_q;
		cmd.accept     = 1'b0;
		cmd.emit_head  = 1'b0;
		cmd.emit_group = 1'b0;
		case (state_q)
			ST_IDLE: begin
				cmd.accept = in_valid;
				if (in_valid && sts.emit_req)
					state_d = ST_HEAD;
			end
			ST_HEAD: begin
				cmd.emit_head = sts.out_free;
				if (sts.out_free)
					state_d = sts.short_run ? ST_IDLE : ST_GROUP;
			end
			ST_GROUP: begin
				cmd.emit_group = sts.out_free;
				if (sts.out_free && sts.final_group)
					state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	assign busy = (state_q != ST_IDLE);

endmodule

/* rtl/brle_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brle_datapath
// Held run, saturating accumulator, emit shift register, mode register and
// output byte register.
// ----------------------------------------------------------------------------
module brle_datapath import brle_pkg::*; #(
	parameter int RUN_BITS = RUN_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        config_write,
	input  logic        config_data,
	input  logic        operation,
	input  logic [2:0]  symbol,
	input  logic [31:0] run_length,
	input  logic        out_stall,
	input  brle_cmd_t   cmd,
	output brle_sts_t   sts,
	output logic        out_valid,
	output logic [7:0]  code_byte,
	output logic        last_byte
);

	localparam int SUM_W = ((RUN_BITS > 32) ? RUN_BITS : 32) + 1;
	localparam logic [SUM_W-1:0] EXC_MAX = SUM_W'({RUN_BITS{1'b1}});

	logic                ends_mode_q;
	logic                pending_q;
	logic [2:0]          run_sym_q;
	logic [RUN_BITS-1:0] run_exc_q;
	logic [2:0]          emit_sym_q;
	logic [RUN_BITS-1:0] emit_exc_q;
	logic                out_valid_q;
	logic [7:0]          byte_q;
	logic                last_q;

	logic                append_ok;
	logic                same_run;
	logic [SUM_W-1:0]    add_a, add_b, sum;
	logic [RUN_BITS-1:0] sat_sum;
	brle_layout_t        lay;
	logic                short_run;
	logic                final_group;
	logic [7:0]          head_byte;
	logic [7:0]          group_byte;

	always_comb begin
		append_ok = (symbol <= SYM_END) && !(symbol == SYM_END && !ends_mode_q)
		            && (run_length != 32'd0);
		same_run  = pending_q && (run_sym_q == symbol);
		add_a     = same_run ? SUM_W'(run_exc_q) : '0;
		add_b     = same_run ? SUM_W'(run_length) : SUM_W'(run_length - 32'd1);
		sum       = add_a + add_b;
		sat_sum   = (sum > EXC_MAX) ? RUN_BITS'(EXC_MAX) : sum[RUN_BITS-1:0];

		lay         = code_layout(emit_sym_q, ends_mode_q);
		short_run   = emit_exc_q < RUN_BITS'(lay.limit);
		final_group = (emit_exc_q[RUN_BITS-1:7] == '0);
		head_byte   = short_run ? (lay.base + emit_exc_q[7:0]) : lay.full;
		group_byte  = final_group ? {1'b0, emit_exc_q[6:0]}
		                          : (GROUP_MORE | {1'b0, emit_exc_q[6:0]});

		sts.emit_req    = (operation == OP_FLUSH) ? pending_q
		                                          : (append_ok && pending_q && !same_run);
		sts.short_run   = short_run;
		sts.final_group = final_group;
		sts.out_free    = !out_valid_q || !out_stall;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ends_mode_q <= 1'b0;
			pending_q   <= 1'b0;
			run_sym_q   <= '0;
			run_exc_q   <= '0;
		end else begin
			if (config_write)
				ends_mode_q <= config_data;
			if (cmd.accept) begin
				if (operation == OP_FLUSH) begin
					pending_q <= 1'b0;
					run_sym_q <= '0;
					run_exc_q <= '0;
				end else if (append_ok) begin
					pending_q <= 1'b1;
					run_sym_q <= symbol;
					run_exc_q <= sat_sum;
				end
			end
		end
	end

	// Snapshot the held run on every request; only used when emission starts.
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			emit_sym_q <= run_sym_q;
			emit_exc_q <= run_exc_q;
		end else if (cmd.emit_head && !short_run) begin
			emit_exc_q <= emit_exc_q - RUN_BITS'(lay.limit);
		end else if (cmd.emit_group) begin
			emit_exc_q <= emit_exc_q >> 7;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.emit_head || cmd.emit_group)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_head) begin
			byte_q <= head_byte;
			last_q <= short_run;
		end else if (cmd.emit_group) begin
			byte_q <= group_byte;
			last_q <= final_group;
		end
	end

	assign out_valid = out_valid_q;
	assign code_byte = byte_q;
	assign last_byte = last_q;

endmodule

/* rtl/bwt_run_length_encoder.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bwt_run_length_encoder
// Merges runs of a symbol and encodes each finished run as a byte stream.
// ----------------------------------------------------------------------------
// Each request is taken while the block is idle. A request that closes a
// held run (a new symbol or a flush) then keeps the input stalled while the
// run's bytes leave through the single output register at one byte per
// cycle while the output does not stall: one byte for a short run, up to
// 1 + ceil(RUN_BITS/7) bytes for a long one (6 at the default RUN_BITS of
// 32). The emit shift register sets the number of bytes. The next request
// is taken as soon as the final byte is loaded, even while that byte waits
// at the output. ends_mode may only be written while idle.
module bwt_run_length_encoder import brle_pkg::*; #(
	parameter int RUN_BITS = RUN_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        config_write,
	input  logic        config_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        operation,
	input  logic [2:0]  symbol,
	input  logic [31:0] run_length,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  code_byte,
	output logic        last_byte
);

	brle_cmd_t cmd;
	brle_sts_t sts;
	logic      busy;

	brle_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.sts      (sts),
		.cmd      (cmd),
		.busy     (busy)
	);

	brle_datapath #(
		.RUN_BITS (RUN_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.config_write (config_write),
		.config_data  (config_data),
		.operation    (operation),
		.symbol       (symbol),
		.run_length   (run_length),
		.out_stall    (out_stall),
		.cmd          (cmd),
		.sts          (sts),
		.out_valid    (out_valid),
		.code_byte    (code_byte),
		.last_byte    (last_byte)
	);

	assign in_stall = busy;

	a_emit_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.accept && sts.emit_req) |=> in_stall)
		else $error("closing request did not start emission");

	a_long_head: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit_head && !sts.short_run) |=> (in_stall && !last_byte))
		else $error("long run head ended emission");

	a_group_end: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit_group && sts.final_group) |=> !in_stall)
		else $error("final group did not release input");

	a_group_flag: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_group |=> (out_valid && (code_byte[7] != last_byte)))
		else $error("group continuation bit disagrees with last_byte");

endmodule
